// ----- src/srec_pkg.sv -----
// ----------------------------------------------------------------------------
// srec_pkg
// Shared types, constants and helper functions for the S-record encoder.
// ----------------------------------------------------------------------------
package srec_pkg;

    // Longest record fragment that one request can produce:
    // 'S', type digit, length (2), four address bytes (8), checksum (2).
    localparam int FRAME_LEN = 14;
    localparam int CNT_W     = $clog2(FRAME_LEN + 1);
    localparam int CHAR_W    = 7;

    localparam logic [3:0]        TYPE_MAX = 4'd9;
    localparam logic [CHAR_W-1:0] ASCII_S  = 7'h53;
    localparam logic [CHAR_W-1:0] ASCII_0  = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_NUL = 7'h00;

    typedef enum logic
    {
        KIND_HEADER = 1'b0,
        KIND_DATA   = 1'b1
    } kind_t;

    typedef struct packed
    {
        logic        kind;
        logic [3:0]  rec_type;
        logic [31:0] rec_addr;
        logic [7:0]  byte_count;
        logic [7:0]  data_byte;
    } item_t;

    // Characters of one fragment; chars[0] goes out first.
    typedef struct packed
    {
        logic [FRAME_LEN-1:0][CHAR_W-1:0] chars;
        logic [CNT_W-1:0]                 len;
        logic                             closes;
        logic                             err;
    } frame_t;

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
        logic [CHAR_W-1:0] c;
        unique case (nib)
            4'h0: c = 7'h30;
            4'h1: c = 7'h31;
            4'h2: c = 7'h32;
            4'h3: c = 7'h33;
            4'h4: c = 7'h34;
            4'h5: c = 7'h35;
            4'h6: c = 7'h36;
            4'h7: c = 7'h37;
            4'h8: c = 7'h38;
            4'h9: c = 7'h39;
            4'hA: c = 7'h41;
            4'hB: c = 7'h42;
            4'hC: c = 7'h43;
            4'hD: c = 7'h44;
            4'hE: c = 7'h45;
            4'hF: c = 7'h46;
        endcase
        return c;
    endfunction

    // Number of address bytes carried by each record type.
    function automatic logic [2:0] addr_len(input logic [3:0] rec_type);
        logic [2:0] n;
        unique case (rec_type)
            4'd0, 4'd1, 4'd5, 4'd9: n = 3'd2;
            4'd2, 4'd8:             n = 3'd3;
            4'd3, 4'd7:             n = 3'd4;
            default:                n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

// ----- src/srec_in_if.sv -----
// ----------------------------------------------------------------------------
// srec_in_if
// Request channel carrying header and data items into the encoder.
// ----------------------------------------------------------------------------
interface srec_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [3:0]  rec_type;
    logic [31:0] rec_addr;
    logic [7:0]  byte_count;
    logic [7:0]  data_byte;

    modport source
    (
        output valid, kind, rec_type, rec_addr, byte_count, data_byte,
        input  ready
    );

    modport sink
    (
        input  valid, kind, rec_type, rec_addr, byte_count, data_byte,
        output ready
    );
endinterface

// ----- src/srec_out_if.sv -----
// ----------------------------------------------------------------------------
// srec_out_if
// Character channel carrying the S-record text out of the encoder.
// ----------------------------------------------------------------------------
interface srec_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] ch;
    logic       last;
    logic       error;

    modport source
    (
        output valid, ch, last, error,
        input  ready
    );

    modport sink
    (
        input  valid, ch, last, error,
        output ready
    );
endinterface

// ----- src/srec_framer.sv -----
// ----------------------------------------------------------------------------
// srec_framer
// Record state and the per-request character fragment builder.
// ----------------------------------------------------------------------------
module srec_framer
(
    input  logic            clk,
    input  logic            rst_n,
    input  srec_pkg::item_t item,
    input  logic            load,
    output srec_pkg::frame_t frame
);

    logic [7:0] sum_acc_reg, sum_acc_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic       record_open_reg, record_open_next;

    logic [2:0]  alen;
    logic [7:0]  len_byte;
    logic [31:0] aligned;
    logic [3:0][7:0] abyte;
    logic [7:0]  hdr_sum;
    logic [7:0]  hdr_chk;
    logic [7:0]  data_sum;
    logic [7:0]  data_chk;
    logic [7:0]  left_dec;

    assign alen     = srec_pkg::addr_len(item.rec_type);
    assign len_byte = {5'b0, alen} + item.byte_count + 8'd1;

    // Left-justify the emitted address bytes so slot 3 is always sent first.
    always_comb
    begin
        unique case (alen)
            3'd2:    aligned = {item.rec_addr[15:0], 16'h0};
            3'd3:    aligned = {item.rec_addr[23:0], 8'h0};
            3'd4:    aligned = item.rec_addr;
            default: aligned = '0;
        endcase
    end

    assign abyte    = aligned;
    assign hdr_sum  = len_byte + abyte[3] + abyte[2] + abyte[1] + abyte[0];
    assign hdr_chk  = ~hdr_sum;
    assign data_sum = sum_acc_reg + item.data_byte;
    assign data_chk = ~data_sum;
    assign left_dec = bytes_left_reg - 8'd1;

    always_comb
    begin
        frame            = '0;
        sum_acc_next     = sum_acc_reg;
        bytes_left_next  = bytes_left_reg;
        record_open_next = record_open_reg;

        if (item.kind == srec_pkg::KIND_HEADER)
        begin
            sum_acc_next     = 8'd0;
            bytes_left_next  = 8'd0;
            record_open_next = 1'b0;
            if (item.rec_type > srec_pkg::TYPE_MAX)
            begin
                frame.chars[0] = srec_pkg::ASCII_NUL;
                frame.len      = srec_pkg::CNT_W'(1);
                frame.closes   = 1'b1;
                frame.err      = 1'b1;
            end
            else
            begin
                frame.chars[0] = srec_pkg::ASCII_S;
                frame.chars[1] = srec_pkg::ASCII_0 + {3'b0, item.rec_type};
                frame.chars[2] = srec_pkg::hex_char(len_byte[7:4]);
                frame.chars[3] = srec_pkg::hex_char(len_byte[3:0]);
                for (int k = 0; k < 4; k++)
                begin
                    if (3'(k) < alen)
                    begin
                        frame.chars[4 + 2 * k] = srec_pkg::hex_char(abyte[3 - k][7:4]);
                        frame.chars[5 + 2 * k] = srec_pkg::hex_char(abyte[3 - k][3:0]);
                    end
                end
                if (item.byte_count == 8'd0)
                begin
                    // Empty record: the checksum follows the last address byte.
                    for (int k = 0; k < 5; k++)
                    begin
                        if (3'(k) == alen)
                        begin
                            frame.chars[4 + 2 * k] = srec_pkg::hex_char(hdr_chk[7:4]);
                            frame.chars[5 + 2 * k] = srec_pkg::hex_char(hdr_chk[3:0]);
                        end
                    end
                    frame.len    = srec_pkg::CNT_W'(6) + srec_pkg::CNT_W'({alen, 1'b0});
                    frame.closes = 1'b1;
                end
                else
                begin
                    frame.len        = srec_pkg::CNT_W'(4) + srec_pkg::CNT_W'({alen, 1'b0});
                    sum_acc_next     = hdr_sum;
                    bytes_left_next  = item.byte_count;
                    record_open_next = 1'b1;
                end
            end
        end
        else if (!record_open_reg)
        begin
            frame.chars[0] = srec_pkg::ASCII_NUL;
            frame.len      = srec_pkg::CNT_W'(1);
            frame.closes   = 1'b1;
            frame.err      = 1'b1;
        end
        else
        begin
            frame.chars[0] = srec_pkg::hex_char(item.data_byte[7:4]);
            frame.chars[1] = srec_pkg::hex_char(item.data_byte[3:0]);
            if (left_dec == 8'd0)
            begin
                frame.chars[2]   = srec_pkg::hex_char(data_chk[7:4]);
                frame.chars[3]   = srec_pkg::hex_char(data_chk[3:0]);
                frame.len        = srec_pkg::CNT_W'(4);
                frame.closes     = 1'b1;
                sum_acc_next     = 8'd0;
                bytes_left_next  = 8'd0;
                record_open_next = 1'b0;
            end
            else
            begin
                frame.len       = srec_pkg::CNT_W'(2);
                sum_acc_next    = data_sum;
                bytes_left_next = left_dec;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_acc_reg     <= 8'd0;
            bytes_left_reg  <= 8'd0;
            record_open_reg <= 1'b0;
        end
        else if (load)
        begin
            sum_acc_reg     <= sum_acc_next;
            bytes_left_reg  <= bytes_left_next;
            record_open_reg <= record_open_next;
        end
    end

    // An open record always has at least one data byte still to come.
    assert property (@(posedge clk) disable iff (!rst_n)
        record_open_reg |-> (bytes_left_reg != 8'd0))
        else $error("open record with no bytes left");

    // A closed record leaves a clean running sum behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        !record_open_reg |-> (sum_acc_reg == 8'd0 && bytes_left_reg == 8'd0))
        else $error("stale state with no record open");

    // Every fragment that closes a record or reports an error leaves no record open.
    assert property (@(posedge clk) disable iff (!rst_n)
        (load && frame.closes) |=> !record_open_reg)
        else $error("record still open after closing fragment");

endmodule

// ----- src/srec_serializer.sv -----
// ----------------------------------------------------------------------------
// srec_serializer
// Fragment buffer and output register that send one character per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module srec_serializer
(
    input  logic             clk,
    input  logic             rst_n,
    input  srec_pkg::frame_t frame,
    input  logic             load,
    output logic             load_ready,
    srec_out_if.source       chars
);

    logic [srec_pkg::FRAME_LEN-1:0][srec_pkg::CHAR_W-1:0] buf_reg, buf_next;
    logic [srec_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       closes_reg, closes_next;
    logic                       err_reg, err_next;

    logic                       out_valid_reg, out_valid_next;
    logic [srec_pkg::CHAR_W-1:0] ch_reg, ch_next;
    logic                       last_reg, last_next;
    logic                       error_reg, error_next;

    logic mv;

    // A character moves to the output register whenever that register is free.
    assign mv         = (cnt_reg != '0) && (!out_valid_reg || chars.ready);
    assign load_ready = (cnt_reg == '0) ||
                        (cnt_reg == srec_pkg::CNT_W'(1) && mv);

    always_comb
    begin
        buf_next    = buf_reg;
        cnt_next    = cnt_reg;
        closes_next = closes_reg;
        err_next    = err_reg;
        if (load)
        begin
            buf_next    = frame.chars;
            cnt_next    = frame.len;
            closes_next = frame.closes;
            err_next    = frame.err;
        end
        else if (mv)
        begin
            buf_next = {{srec_pkg::CHAR_W{1'b0}}, buf_reg[srec_pkg::FRAME_LEN-1:1]};
            cnt_next = cnt_reg - srec_pkg::CNT_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        ch_next        = ch_reg;
        last_next      = last_reg;
        error_next     = error_reg;
        if (mv)
        begin
            out_valid_next = 1'b1;
            ch_next        = buf_reg[0];
            last_next      = closes_reg && (cnt_reg == srec_pkg::CNT_W'(1));
            error_next     = err_reg;
        end
        else if (chars.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg    <= buf_next;
        closes_reg <= closes_next;
        err_reg    <= err_next;
        ch_reg     <= ch_next;
        last_reg   <= last_next;
        error_reg  <= error_next;
    end

    assign chars.valid = out_valid_reg;
    assign chars.ch    = ch_reg;
    assign chars.last  = last_reg;
    assign chars.error = error_reg;

    // A new fragment only lands on an empty buffer or on one draining its final character.
    assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (cnt_reg == '0 || (cnt_reg == srec_pkg::CNT_W'(1) && mv)))
        else $error("fragment loaded over pending characters");

    // The buffer never holds more than one full fragment.
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= srec_pkg::CNT_W'(srec_pkg::FRAME_LEN))
        else $error("character count overflow");

    // Draining without a new load takes exactly one character off.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mv && !load) |=> (cnt_reg == $past(cnt_reg) - srec_pkg::CNT_W'(1)))
        else $error("character count out of step");

    // An error result is always a single, final character.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && error_reg) |-> last_reg)
        else $error("error result without last");

endmodule

// ----- src/srecord_encoder_unit.sv -----
// ----------------------------------------------------------------------------
// srecord_encoder_unit
// S-record text encoder, one ASCII character per output request.
// ----------------------------------------------------------------------------
// The item channel takes header requests (kind 0) and data-byte requests
// (kind 1). A header emits 'S', the type digit, the length byte and 0, 2, 3
// or 4 address bytes as uppercase hex; each data byte emits two hex digits.
// The checksum follows the last data byte, or the header when the count is
// zero, and its final character has last set. A bad type, or data with no
// record open, gives one character 0 with last and error set.
// The first character of an accepted request goes into the fragment buffer and
// from there into the output register. Throughput is one character per cycle
// while the receiver keeps ready high, set by the single output register: a data
// byte gives 2 characters (4 when it closes the record) and a header gives 1 to 14
// characters. The next request is taken in the cycle the previous one's last
// character moves to the output register.
// Reset clears the running sum, the remaining count, the open-record flag and
// all pending characters. When the receiver stalls, the output register holds
// its character and the buffer stops; item ready stays low while the buffer
// holds more than the one character that is moving out.
// ----------------------------------------------------------------------------
module srecord_encoder_unit
(
    input  logic      clk,
    input  logic      rst_n,
    srec_in_if.sink   item,
    srec_out_if.source chars
);

    srec_pkg::item_t  item_pl;
    srec_pkg::frame_t frame;
    logic             load;
    logic             load_ready;

    assign item_pl.kind       = item.kind;
    assign item_pl.rec_type   = item.rec_type;
    assign item_pl.rec_addr   = item.rec_addr;
    assign item_pl.byte_count = item.byte_count;
    assign item_pl.data_byte  = item.data_byte;

    assign item.ready = load_ready;
    assign load       = item.valid && load_ready;

    srec_framer u_framer
    (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_pl),
        .load  (load),
        .frame (frame)
    );

    srec_serializer u_serializer
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame      (frame),
        .load       (load),
        .load_ready (load_ready),
        .chars      (chars)
    );

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for srecord_encoder_unit. A queue of header and
// data requests drives the item channel in random bursts. Every accepted
// request updates a local model of the record state, and that model queues
// the characters it predicts. A monitor checks each character against the
// oldest prediction while the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_REQS = 150;
    localparam logic [srec_pkg::CHAR_W-1:0] ASCII_A = 7'h41;
    // Address byte count per record type, type 0 in the low bits.
    localparam logic [29:0] ADDR_BYTES_BY_TYPE =
        {3'd2, 3'd3, 3'd4, 3'd0, 3'd2, 3'd0, 3'd4, 3'd3, 3'd2, 3'd2};

    typedef struct packed
    {
        logic [srec_pkg::CHAR_W-1:0] ch;
        logic                        last;
        logic                        error;
    } text_char_t;

    typedef struct packed
    {
        srec_pkg::item_t req;
        logic            drain;
    } pending_t;

    logic clk;
    logic rst_n;

    srec_in_if  item_bus();
    srec_out_if char_bus();

    srecord_encoder_unit dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_bus),
        .chars (char_bus)
    );

    pending_t   pending_reqs[$];
    text_char_t expected_text[$];

    logic [7:0] rec_sum  = 8'd0;
    logic [7:0] rec_left = 8'd0;
    logic       rec_open = 1'b0;

    int mismatch_count = 0;
    int cycle_count    = 0;
    int burst_left;
    int gap_left;
    int stall_mode;
    int mode_left;
    int stall_phase;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------
    // Record model
    // ------------------------------------------------------------------
    function automatic logic [srec_pkg::CHAR_W-1:0] nibble_char(input logic [3:0] nib);
        if (nib < 4'd10)
            return srec_pkg::ASCII_0 + srec_pkg::CHAR_W'(nib);
        return ASCII_A + srec_pkg::CHAR_W'(nib - 4'd10);
    endfunction

    function automatic void queue_char(input logic [srec_pkg::CHAR_W-1:0] c,
                                       input logic l, input logic e);
        text_char_t t;
        t.ch    = c;
        t.last  = l;
        t.error = e;
        expected_text.push_back(t);
    endfunction

    function automatic void queue_byte(input logic [7:0] b, input logic closing);
        queue_char(nibble_char(b[7:4]), 1'b0, 1'b0);
        queue_char(nibble_char(b[3:0]), closing, 1'b0);
    endfunction

    function automatic void queue_summed(input logic [7:0] b);
        rec_sum = rec_sum + b;
        queue_byte(b, 1'b0);
    endfunction

    function automatic void queue_checksum();
        queue_byte(~rec_sum, 1'b1);
        rec_open = 1'b0;
        rec_left = 8'd0;
        rec_sum  = 8'd0;
    endfunction

    function automatic void predict_text(input srec_pkg::item_t r);
        logic [2:0] n_addr;
        int         k;
        if (r.kind == srec_pkg::KIND_HEADER)
        begin
            rec_open = 1'b0;
            rec_left = 8'd0;
            rec_sum  = 8'd0;
            if (r.rec_type > srec_pkg::TYPE_MAX)
            begin
                queue_char(srec_pkg::ASCII_NUL, 1'b1, 1'b1);
                return;
            end
            n_addr = ADDR_BYTES_BY_TYPE[r.rec_type * 3 +: 3];
            queue_char(srec_pkg::ASCII_S, 1'b0, 1'b0);
            queue_char(srec_pkg::ASCII_0 + srec_pkg::CHAR_W'(r.rec_type), 1'b0, 1'b0);
            queue_summed(8'(n_addr) + r.byte_count + 8'd1);
            for (k = n_addr; k > 0; k--)
                queue_summed(r.rec_addr[8 * (k - 1) +: 8]);
            if (r.byte_count == 8'd0)
                queue_checksum();
            else
            begin
                rec_open = 1'b1;
                rec_left = r.byte_count;
            end
        end
        else if (!rec_open)
            queue_char(srec_pkg::ASCII_NUL, 1'b1, 1'b1);
        else
        begin
            queue_summed(r.data_byte);
            rec_left = rec_left - 8'd1;
            if (rec_left == 8'd0)
                queue_checksum();
        end
    endfunction

    // ------------------------------------------------------------------
    // Request building; fields that a kind ignores still get random values.
    // ------------------------------------------------------------------
    function automatic void add_header(input logic [3:0] t, input logic [31:0] a,
                                       input logic [7:0] cnt, input logic drain);
        pending_t p;
        p.req.kind       = srec_pkg::KIND_HEADER;
        p.req.rec_type   = t;
        p.req.rec_addr   = a;
        p.req.byte_count = cnt;
        p.req.data_byte  = 8'($urandom);
        p.drain          = drain;
        pending_reqs.push_back(p);
    endfunction

    function automatic void add_data(input logic [7:0] b);
        pending_t p;
        p.req.kind       = srec_pkg::KIND_DATA;
        p.req.rec_type   = 4'($urandom);
        p.req.rec_addr   = $urandom;
        p.req.byte_count = 8'($urandom);
        p.req.data_byte  = b;
        p.drain          = 1'b0;
        pending_reqs.push_back(p);
    endfunction

    // ------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : req_driver
        srec_pkg::item_t taken;
        logic            offer;
        if (!rst_n)
        begin
            item_bus.valid      <= 1'b0;
            item_bus.kind       <= srec_pkg::KIND_HEADER;
            item_bus.rec_type   <= 4'd0;
            item_bus.rec_addr   <= 32'd0;
            item_bus.byte_count <= 8'd0;
            item_bus.data_byte  <= 8'd0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            offer = 1'b0;
            if (item_bus.valid && item_bus.ready)
            begin
                taken.kind       = item_bus.kind;
                taken.rec_type   = item_bus.rec_type;
                taken.rec_addr   = item_bus.rec_addr;
                taken.byte_count = item_bus.byte_count;
                taken.data_byte  = item_bus.data_byte;
                predict_text(taken);
                void'(pending_reqs.pop_front());
                if (burst_left > 0)
                    burst_left--;
            end
            if (item_bus.valid && !item_bus.ready)
                offer = 1'b1;
            else
            begin
                if (burst_left == 0)
                begin
                    if ($urandom_range(0, 5) == 0)
                    begin
                        burst_left = 40;
                        gap_left   = 0;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                if (gap_left > 0)
                    gap_left--;
                else if (pending_reqs.size() != 0 &&
                         !(pending_reqs[0].drain && expected_text.size() != 0))
                begin
                    offer = 1'b1;
                    item_bus.kind       <= pending_reqs[0].req.kind;
                    item_bus.rec_type   <= pending_reqs[0].req.rec_type;
                    item_bus.rec_addr   <= pending_reqs[0].req.rec_addr;
                    item_bus.byte_count <= pending_reqs[0].req.byte_count;
                    item_bus.data_byte  <= pending_reqs[0].req.data_byte;
                end
            end
            item_bus.valid <= offer;
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall pattern: always ready, coin flips, rare stalls, or a
    // fixed three-in-eight stall.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : text_sink
        if (!rst_n)
        begin
            char_bus.ready <= 1'b0;
            stall_mode  = 0;
            mode_left   = 0;
            stall_phase = 0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 120);
            end
            mode_left--;
            stall_phase = (stall_phase + 1) % 8;
            case (stall_mode)
                0:       char_bus.ready <= 1'b1;
                1:       char_bus.ready <= 1'($urandom_range(0, 1));
                2:       char_bus.ready <= ($urandom_range(0, 7) != 0);
                default: char_bus.ready <= (stall_phase >= 3);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : text_monitor
        text_char_t want;
        if (rst_n && char_bus.valid && char_bus.ready)
        begin
            if (expected_text.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected char: got ch=%02h last=%0b error=%0b",
                         $time, char_bus.ch, char_bus.last, char_bus.error);
            end
            else
            begin
                want = expected_text.pop_front();
                if (char_bus.ch !== want.ch || char_bus.last !== want.last ||
                    char_bus.error !== want.error)
                begin
                    mismatch_count++;
                    $write("%0t: char mismatch: expected ch=%02h last=%0b error=%0b",
                           $time, want.ch, want.last, want.error);
                    $display(", got ch=%02h last=%0b error=%0b",
                             char_bus.ch, char_bus.last, char_bus.error);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("srecord_encoder_unit: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int         seq_count;
        int         pick;
        int         n;
        int         i;
        logic [7:0] cnt;
        logic       drain;
        rst_n = 1'b0;

        // Directed: data with no record open, every type with an empty record,
        // bad types, a short full record, a wrapped length byte, a record
        // abandoned by a new header, and a record closed by a bad type.
        add_data(8'h3C);
        add_header(4'd0, 32'h0000_0000, 8'd0, 1'b0);
        add_header(4'd1, 32'hFFFF_FFFF, 8'd0, 1'b0);
        add_header(4'd2, 32'h1234_5678, 8'd0, 1'b0);
        add_header(4'd3, 32'hFFFF_FFFF, 8'd0, 1'b0);
        add_header(4'd4, 32'hDEAD_BEEF, 8'd0, 1'b0);
        add_header(4'd5, 32'h0000_FFFF, 8'd0, 1'b0);
        add_header(4'd6, 32'hA5A5_5A5A, 8'd0, 1'b0);
        add_header(4'd7, 32'h8000_0001, 8'd0, 1'b0);
        add_header(4'd8, 32'h00FF_00FF, 8'd0, 1'b0);
        add_header(4'd9, 32'hC001_D00D, 8'd0, 1'b0);
        add_header(4'd10, $urandom, 8'd0, 1'b0);
        add_header(4'd12, $urandom, 8'd5, 1'b0);
        add_header(4'd15, $urandom, 8'hFF, 1'b0);
        add_header(4'd3, 32'hFFFF_FFFF, 8'd2, 1'b1);
        add_data(8'h00);
        add_data(8'hFF);
        add_header(4'd1, 32'h0000_0000, 8'hFF, 1'b0);
        add_data(8'hA5);
        add_header(4'd7, 32'h7654_3210, 8'd1, 1'b0);
        add_data(8'h5A);
        add_header(4'd2, $urandom, 8'd3, 1'b0);
        add_data(8'h81);
        add_header(4'd11, $urandom, 8'd1, 1'b0);
        add_data(8'h7E);

        // Random: mostly complete records with random content, the rest
        // broken records, bad types and lone data bytes.
        n         = pending_reqs.size();
        seq_count = 0;
        while (pending_reqs.size() < n + RANDOM_REQS)
        begin
            pick  = $urandom_range(0, 9);
            drain = (seq_count % 8 == 0);
            seq_count++;
            if (pick <= 6)
            begin
                cnt = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(7, 24))
                                                   : 8'($urandom_range(0, 6));
                add_header(4'($urandom_range(0, 9)), $urandom, cnt, drain);
                for (i = 0; i < cnt; i++)
                    add_data(8'($urandom));
            end
            else if (pick == 7)
            begin
                cnt = 8'($urandom_range(1, 255));
                add_header(4'($urandom_range(0, 9)), $urandom, cnt, drain);
                for (i = 0; i < $urandom_range(0, 4) && i < cnt - 1; i++)
                    add_data(8'($urandom));
            end
            else if (pick == 8)
                add_header(4'($urandom_range(10, 15)), $urandom, 8'($urandom), drain);
            else
                add_data(8'($urandom));
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || expected_text.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatch_count == 0 && expected_text.size() == 0)
            $display("srecord_encoder_unit: match");
        else
            $display("srecord_encoder_unit: mismatch");
        $finish;
    end
endmodule
